### rtl/gbn_pkg.sv
// shared types and constants for the greedy box suppression block
`timescale 1ns / 1ps
package gbn_pkg;

  // default number of kept boxes per frame
  localparam int KEPT_DEPTH_DEF = 64;

  // field widths
  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 15;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int AREA_W   = 2 * SIZE_W;
  localparam int UNION_W  = AREA_W + 1;
  localparam int THRESH_W = 9;
  localparam int SLOT_W   = 6;
  localparam int FRAC_SH  = 8;
  localparam int LHS_W    = AREA_W + FRAC_SH;
  localparam int RHS_W    = UNION_W + THRESH_W;

  // overlap limit after reset, about 0.45 in units of 1/256
  localparam logic [THRESH_W-1:0] THRESH_RST = 9'd115;

  // one box as held in the kept store
  typedef struct packed {
    logic        [SIZE_W-1:0]  height;
    logic        [SIZE_W-1:0]  width;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] left;
  } gbn_box_t;

  // one classified item handed from front to back
  typedef struct packed {
    gbn_box_t                  box;
    logic signed [EDGE_W-1:0]  right;
    logic signed [EDGE_W-1:0]  bottom;
    logic        [AREA_W-1:0]  area;
    logic                      frame_start;
  } gbn_item_t;

  // one result item
  typedef struct packed {
    logic              keep;
    logic [SLOT_W-1:0] slot;
    logic              store_full;
  } gbn_res_t;

endpackage

### rtl/greedy_box_nms_core.sv
// Greedy box suppression core: boxes sorted by falling score go in, one
// keep / slot / store_full item comes out per box.
//
// Input queue: drive in_box_* and in_frame_start with in_push; the item is
// taken on a clock edge with in_push high and in_full low. A two-entry queue
// holds items while the back end is busy.
// Result queue: while out_empty is low the oldest result is on out_*; it is
// taken on a clock edge with out_pop high. A held result stalls only the
// final step of the next box; comparisons carry on meanwhile.
// Threshold: cfg_iou_thresh is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high. Write it only while the core is idle.
// Comparison: a box is compared against every kept box in turn, the single
// read port of the kept store feeding the five-stage overlap pipeline one
// entry a cycle. A frame start box, or any box with an empty store, skips
// the comparisons and goes straight from pick-up to the final step; the back
// end then returns to idle before it takes the next item.
// Reset: synchronous, active low; the store empties, queues clear and the
// threshold returns to 115/256. The store needs no clearing pass.
`timescale 1ns / 1ps
module greedy_box_nms_core #(
  parameter int KEPT_DEPTH = gbn_pkg::KEPT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [gbn_pkg::COORD_W-1:0]  in_box_left,
  input  logic signed [gbn_pkg::COORD_W-1:0]  in_box_top,
  input  logic        [gbn_pkg::SIZE_W-1:0]   in_box_width,
  input  logic        [gbn_pkg::SIZE_W-1:0]   in_box_height,
  input  logic                                in_frame_start,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_keep,
  output logic        [gbn_pkg::SLOT_W-1:0]   out_slot,
  output logic                                out_store_full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [gbn_pkg::THRESH_W-1:0] cfg_iou_thresh
);
  import gbn_pkg::*;

  logic [THRESH_W-1:0] thresh_r;
  logic                q_valid;
  logic                q_take;
  gbn_item_t           q_item;
  logic                res_valid;
  gbn_res_t            res;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_iou_thresh;
    end
  end

  gbn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_box_left    (in_box_left),
    .in_box_top     (in_box_top),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_frame_start (in_frame_start),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .q_item         (q_item)
  );

  gbn_back #(
    .KEPT_DEPTH (KEPT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .thresh    (thresh_r),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res       (res)
  );

  // result ports
  assign out_empty      = !res_valid;
  assign out_keep       = res.keep;
  assign out_slot       = res.slot;
  assign out_store_full = res.store_full;

endmodule

### rtl/gbn_front.sv
// front end: accepts boxes, works out edges and area, queues them for the back end
`timescale 1ns / 1ps
module gbn_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic signed [gbn_pkg::COORD_W-1:0]    in_box_left,
  input  logic signed [gbn_pkg::COORD_W-1:0]    in_box_top,
  input  logic        [gbn_pkg::SIZE_W-1:0]     in_box_width,
  input  logic        [gbn_pkg::SIZE_W-1:0]     in_box_height,
  input  logic                                  in_frame_start,
  output logic                                  q_valid,
  input  logic                                  q_take,
  output gbn_pkg::gbn_item_t                    q_item
);
  import gbn_pkg::*;

  gbn_item_t   q_mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push_ok;
  logic        pop_ok;
  gbn_item_t   item;

  // classify the incoming box: right and bottom edges, own area
  always_comb begin
    item.box.left    = in_box_left;
    item.box.top     = in_box_top;
    item.box.width   = in_box_width;
    item.box.height  = in_box_height;
    item.right       = EDGE_W'(in_box_left) + $signed({2'b00, in_box_width});
    item.bottom      = EDGE_W'(in_box_top) + $signed({2'b00, in_box_height});
    item.area        = AREA_W'(in_box_width) * AREA_W'(in_box_height);
    item.frame_start = in_frame_start;
  end

  // two-entry queue between front and back
  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_take && q_valid;

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

  // queue occupancy stays within its two entries
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("front queue count out of range");

  // a take from an empty queue would lose track of order
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("back took from empty front queue");

endmodule

### rtl/gbn_iou.sv
// overlap pipeline: decides whether a stored box overlaps the current one too much
`timescale 1ns / 1ps
module gbn_iou (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                e_valid,
  input  gbn_pkg::gbn_box_t                   e_box,
  input  gbn_pkg::gbn_item_t                  cur,
  input  logic [gbn_pkg::THRESH_W-1:0]        thresh,
  output logic                                hit_valid,
  output logic                                hit
);
  import gbn_pkg::*;

  logic                      v1_r, v2_r, v3_r, v4_r, v5_r;
  // stage 1
  logic signed [EDGE_W-1:0]  r2_r, b2_r;
  logic signed [COORD_W-1:0] x1_r, y1_r;
  logic [SIZE_W-1:0]         w2_r, h2_r;
  // stage 2
  logic [SIZE_W-1:0]         iw_r, ih_r;
  logic [SIZE_W-1:0]         w2b_r, h2b_r;
  // stage 3
  logic [AREA_W-1:0]         inter_r, a2_r;
  // stage 4
  logic [UNION_W-1:0]        uni_r;
  logic [AREA_W-1:0]         inter4_r;
  // stage 5
  logic [RHS_W-1:0]          lhs_r, rhs_r;

  logic signed [EDGE_W-1:0]  x2, y2;
  logic signed [EDGE_W:0]    dx, dy;

  // valid bits along the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= e_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: far edges of the stored box, near corner of the overlap
  always_ff @(posedge clk) begin
    r2_r <= EDGE_W'(e_box.left) + $signed({2'b00, e_box.width});
    b2_r <= EDGE_W'(e_box.top) + $signed({2'b00, e_box.height});
    x1_r <= (cur.box.left > e_box.left) ? cur.box.left : e_box.left;
    y1_r <= (cur.box.top > e_box.top) ? cur.box.top : e_box.top;
    w2_r <= e_box.width;
    h2_r <= e_box.height;
  end

  // stage 2: overlap width and height, clamped at zero
  always_comb begin
    x2 = (cur.right < r2_r) ? cur.right : r2_r;
    y2 = (cur.bottom < b2_r) ? cur.bottom : b2_r;
    dx = (EDGE_W + 1)'(x2) - (EDGE_W + 1)'(x1_r);
    dy = (EDGE_W + 1)'(y2) - (EDGE_W + 1)'(y1_r);
  end

  always_ff @(posedge clk) begin
    iw_r  <= (dx > 0) ? dx[SIZE_W-1:0] : '0;
    ih_r  <= (dy > 0) ? dy[SIZE_W-1:0] : '0;
    w2b_r <= w2_r;
    h2b_r <= h2_r;
  end

  // stage 3: overlap area and stored box area
  always_ff @(posedge clk) begin
    inter_r <= AREA_W'(iw_r) * AREA_W'(ih_r);
    a2_r    <= AREA_W'(w2b_r) * AREA_W'(h2b_r);
  end

  // stage 4: union area
  always_ff @(posedge clk) begin
    uni_r    <= UNION_W'(cur.area) + UNION_W'(a2_r) - UNION_W'(inter_r);
    inter4_r <= inter_r;
  end

  // stage 5: scale both sides of the ratio test
  always_ff @(posedge clk) begin
    lhs_r <= RHS_W'({inter4_r, {FRAC_SH{1'b0}}});
    rhs_r <= RHS_W'(thresh) * RHS_W'(uni_r);
  end

  assign hit_valid = v5_r;
  assign hit       = (lhs_r > rhs_r);

  // the overlap can never be wider than the current box
  a_iw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> iw_r <= cur.box.width) else $error("overlap wider than box");

  // overlap area never exceeds the union
  a_inter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> UNION_W'(inter4_r) <= uni_r) else $error("overlap exceeds union");

endmodule

### rtl/gbn_back.sv
// back end: walks the kept store through the overlap pipeline, keeps survivors
`timescale 1ns / 1ps
module gbn_back #(
  parameter int KEPT_DEPTH = gbn_pkg::KEPT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [gbn_pkg::THRESH_W-1:0]        thresh,
  input  logic                                q_valid,
  output logic                                q_take,
  input  gbn_pkg::gbn_item_t                  q_item,
  output logic                                res_valid,
  input  logic                                res_pop,
  output gbn_pkg::gbn_res_t                   res
);
  import gbn_pkg::*;

  localparam int CNT_W = $clog2(KEPT_DEPTH + 1);
  localparam int IDX_W = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(KEPT_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  state_t            state_r;
  gbn_item_t         cur_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  iss_r;
  logic [CNT_W-1:0]  done_r;
  logic              hit_r;
  logic              res_vld_r;
  gbn_res_t          res_r;

  gbn_box_t          mem [KEPT_DEPTH];
  logic              rd_en;
  logic              rd_vld_r;
  gbn_box_t          rd_data_r;
  logic              wr_en;

  logic              hit_valid;
  logic              hit;
  logic [CNT_W-1:0]  n_new;
  logic              res_free;
  logic              keep;
  logic              store;

  assign n_new    = q_item.frame_start ? '0 : count_r;
  assign res_free = !res_vld_r || res_pop;
  assign keep     = !hit_r;
  assign store    = keep && (n_r < DEPTH_C);
  assign q_take   = (state_r == ST_IDLE) && q_valid;
  assign rd_en    = (state_r == ST_ISSUE);
  assign wr_en    = (state_r == ST_DECIDE) && res_free && store;

  // kept store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[n_r[IDX_W-1:0]] <= cur_r.box;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  gbn_iou u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .e_valid   (rd_vld_r),
    .e_box     (rd_data_r),
    .cur       (cur_r),
    .thresh    (thresh),
    .hit_valid (hit_valid),
    .hit       (hit)
  );

  // sequencer: load item, issue reads, wait for the pipeline, decide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      n_r       <= '0;
      iss_r     <= '0;
      done_r    <= '0;
      hit_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (res_pop) begin
        res_vld_r <= 1'b0;
      end
      if (hit_valid) begin
        done_r <= done_r + 1'b1;
        hit_r  <= hit_r | hit;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_item;
            n_r     <= n_new;
            iss_r   <= '0;
            done_r  <= '0;
            hit_r   <= 1'b0;
            state_r <= (n_new == '0) ? ST_DECIDE : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          iss_r <= iss_r + 1'b1;
          if (CNT_W'(iss_r + 1'b1) == n_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done_r == n_r) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (res_free) begin
            res_vld_r        <= 1'b1;
            res_r.keep       <= keep;
            res_r.slot       <= store ? SLOT_W'(n_r) : '0;
            res_r.store_full <= keep && !store;
            count_r          <= store ? CNT_W'(n_r + 1'b1) : n_r;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

  // kept count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("kept count beyond store depth");

  // no more comparisons come back than were issued
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> done_r <= n_r) else $error("extra comparison returned");

  // a suppressed box carries no slot and no full flag
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && !res_r.keep |-> res_r.slot == '0 && !res_r.store_full)
    else $error("suppressed item carries slot or full flag");

  // the store is written only as a result is produced
  a_wr_with_res: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> res_vld_r && res_r.keep) else $error("store write without kept result");

endmodule

### bench/greedy_box_nms_core_tb.sv
// testbench for the greedy box suppression core, self-checking against its own predictor
`timescale 1ns / 1ps
module greedy_box_nms_core_tb;
  import gbn_pkg::*;

  localparam int DEPTH       = KEPT_DEPTH_DEF;
  localparam int ITEMS_PHASE = 70;
  localparam int SETTLE_CYC  = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic signed [COORD_W-1:0] in_box_left;
  logic signed [COORD_W-1:0] in_box_top;
  logic [SIZE_W-1:0]     in_box_width;
  logic [SIZE_W-1:0]     in_box_height;
  logic                  in_frame_start;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_keep;
  logic [SLOT_W-1:0]     out_slot;
  logic                  out_store_full;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [THRESH_W-1:0]   cfg_iou_thresh;

  // predictor state: kept boxes of the current frame and the overlap limit
  gbn_box_t            kept_store [DEPTH];
  int                  kept_total;
  logic [THRESH_W-1:0] overlap_limit;
  gbn_res_t            expected_results [$];

  int  mismatches;
  int  boxes_sent;
  int  sink_hold;
  bit  src_eager;
  bit  sink_eager;

  greedy_box_nms_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_box_left    (in_box_left),
    .in_box_top     (in_box_top),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_frame_start (in_frame_start),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_keep       (out_keep),
    .out_slot       (out_slot),
    .out_store_full (out_store_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_iou_thresh (cfg_iou_thresh)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #25_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // division-free overlap test of a new box against one kept box
  function automatic bit overlap_exceeds(gbn_box_t a, gbn_box_t b);
    longint al, at, ar, ab, bl, bt, br, bb;
    longint x1, y1, x2, y2, iw, ih, inter, uni, lim;
    al = $signed(a.left);
    at = $signed(a.top);
    bl = $signed(b.left);
    bt = $signed(b.top);
    ar = al + longint'(a.width);
    ab = at + longint'(a.height);
    br = bl + longint'(b.width);
    bb = bt + longint'(b.height);
    x1 = (al > bl) ? al : bl;
    y1 = (at > bt) ? at : bt;
    x2 = (ar < br) ? ar : br;
    y2 = (ab < bb) ? ab : bb;
    iw = (x2 > x1) ? x2 - x1 : 0;
    ih = (y2 > y1) ? y2 - y1 : 0;
    inter = iw * ih;
    uni = longint'(a.width) * longint'(a.height)
        + longint'(b.width) * longint'(b.height) - inter;
    lim = longint'(overlap_limit);
    return (inter * 256) > (lim * uni);
  endfunction

  // greedy decision for one box, updating the kept store
  function automatic gbn_res_t judge_box(gbn_box_t b, bit frame_start);
    gbn_res_t r;
    int       n;
    bit       survive;
    if (frame_start) kept_total = 0;
    n = kept_total;
    survive = 1'b1;
    for (int i = 0; i < n && survive; i++)
      if (overlap_exceeds(b, kept_store[i])) survive = 1'b0;
    r = '0;
    r.keep = survive;
    if (survive) begin
      if (n < DEPTH) begin
        kept_store[n] = b;
        r.slot = SLOT_W'(n);
        kept_total = n + 1;
      end else begin
        r.store_full = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic gbn_box_t mk_box(int l, int t, int w, int h);
    gbn_box_t b;
    if (w < 0) w = 0;
    if (w > 32767) w = 32767;
    if (h < 0) h = 0;
    if (h > 32767) h = 32767;
    b.left   = COORD_W'(l);
    b.top    = COORD_W'(t);
    b.width  = SIZE_W'(w);
    b.height = SIZE_W'(h);
    return b;
  endfunction

  function automatic int src_gap();
    int r;
    if (src_eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic int sink_stall();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // offer one box item and wait for it to be taken
  task automatic send_box(input gbn_box_t b, input bit frame_start);
    int gap;
    in_push        <= 1'b1;
    in_box_left    <= b.left;
    in_box_top     <= b.top;
    in_box_width   <= b.width;
    in_box_height  <= b.height;
    in_frame_start <= frame_start;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_results.insert(expected_results.size(), judge_box(b, frame_start));
    boxes_sent++;
    gap = src_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_push <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  // threshold write, only with the core idle
  task automatic write_thresh(input logic [THRESH_W-1:0] v);
    drain();
    cfg_valid      <= 1'b1;
    cfg_iou_thresh <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    overlap_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // result side: random pop stalls and field checks
  always @(posedge clk) begin : result_sink
    gbn_res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no box waiting: keep %0d slot %0d store_full %0d",
                 out_keep, out_slot, out_store_full);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_keep !== want.keep) begin
            $error("keep: expected %0d, actual %0d", want.keep, out_keep);
            mismatches++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_slot);
            mismatches++;
          end
          if (out_store_full !== want.store_full) begin
            $error("store_full: expected %0d, actual %0d", want.store_full, out_store_full);
            mismatches++;
          end
        end
      end
      if (sink_hold > 0 && !sink_eager) begin
        out_pop <= 1'b0;
        sink_hold--;
      end else begin
        out_pop <= 1'b1;
        sink_hold = 0;
        if (!sink_eager && $urandom_range(0, 3) == 0) sink_hold = sink_stall();
      end
    end
  end

  // extreme coordinates, empty boxes, zero union, limit crossing
  task automatic test_corners();
    send_box(mk_box(-32768, -32768, 32767, 32767), 1'b1);
    send_box(mk_box(-32768, -32768, 32767, 32767), 1'b0);
    send_box(mk_box(32767, 32767, 32767, 32767), 1'b0);
    send_box(mk_box(0, 0, 0, 0), 1'b0);
    send_box(mk_box(0, 0, 0, 0), 1'b0);
    send_box(mk_box(100, 100, 0, 50), 1'b0);
    send_box(mk_box(1000, 1000, 160, 160), 1'b0);
    // ratio one half, above the reset limit
    send_box(mk_box(1000, 1000, 160, 80), 1'b0);
    // ratio just under the reset limit
    send_box(mk_box(1000, 1000, 160, 70), 1'b0);
    send_box(mk_box(5, 5, 16, 16), 1'b1);
    send_box(mk_box(-20, -20, 32, 32), 1'b0);
    send_box(mk_box(16'sh5555, -21846, 15'h2AAA, 15'h5555), 1'b0);
    drain();
  endtask

  // lowest limit, limit that never suppresses, and one below it
  task automatic test_thresholds();
    write_thresh(9'd0);
    send_box(mk_box(0, 0, 160, 160), 1'b1);
    send_box(mk_box(159, 159, 160, 160), 1'b0);
    send_box(mk_box(160, 0, 160, 160), 1'b0);
    write_thresh(9'd256);
    send_box(mk_box(0, 0, 160, 160), 1'b1);
    send_box(mk_box(0, 0, 160, 160), 1'b0);
    send_box(mk_box(0, 0, 160, 160), 1'b0);
    write_thresh(9'd255);
    send_box(mk_box(0, 0, 160, 160), 1'b1);
    send_box(mk_box(0, 0, 160, 160), 1'b0);
    write_thresh(THRESH_RST);
  endtask

  // fill every slot with disjoint boxes, then overflow
  task automatic test_store_full();
    for (int k = 0; k < DEPTH; k++)
      send_box(mk_box(-32768 + (k % 8) * 8192, -32768 + (k / 8) * 8192, 4096, 4096),
               k == 0);
    // survivor with nowhere to go
    send_box(mk_box(-32768 + 5000, -32768 + 5000, 100, 100), 1'b0);
    send_box(mk_box(0, 0, 0, 0), 1'b0);
    // suppressed while full
    send_box(mk_box(-32768, -32768, 4096, 4096), 1'b0);
    send_box(mk_box(0, 0, 64, 64), 1'b1);
    drain();
  endtask

  // one frame of random boxes: clustered, disjoint grid, or raw noise
  task automatic random_frame();
    int kind, len, c, l, t, w, h, gx, gy;
    int cx [4];
    int cy [4];
    int cw [4];
    int ch [4];
    bit fs;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 4; i++) begin
      cx[i] = $urandom_range(0, 65535) - 32768;
      cy[i] = $urandom_range(0, 65535) - 32768;
      cw[i] = $urandom_range(16, 3000);
      ch[i] = $urandom_range(16, 3000);
    end
    if (kind < 65) len = $urandom_range(1, 40);
    else if (kind < 85) len = $urandom_range(60, 72);
    else len = $urandom_range(1, 20);
    for (int k = 0; k < len; k++) begin
      fs = (k == 0);
      if (kind < 65) begin
        c = $urandom_range(0, 3);
        l = cx[c] + $urandom_range(0, cw[c] / 2) - cw[c] / 4;
        t = cy[c] + $urandom_range(0, ch[c] / 2) - ch[c] / 4;
        w = cw[c] + $urandom_range(0, cw[c] / 2) - cw[c] / 4;
        h = ch[c] + $urandom_range(0, ch[c] / 2) - ch[c] / 4;
      end else if (kind < 85) begin
        gx = k % 8;
        gy = (k / 8) % 8;
        w = $urandom_range(0, 4000);
        h = $urandom_range(0, 4000);
        l = -32768 + gx * 8192 + $urandom_range(0, 8191 - w);
        t = -32768 + gy * 8192 + $urandom_range(0, 8191 - h);
      end else begin
        l = $urandom_range(0, 65535);
        t = $urandom_range(0, 65535);
        w = $urandom_range(0, 32767);
        h = $urandom_range(0, 32767);
        if (k > 0) fs = ($urandom_range(0, 7) == 0);
      end
      send_box(mk_box(l, t, w, h), fs);
      // occasional full pause until the core has answered everything
      if ($urandom_range(0, 79) == 0) drain();
    end
  endtask

  // random frames across several limits, with eager stretches on each side
  task automatic test_random();
    logic [THRESH_W-1:0] limits [7];
    int start;
    limits = '{THRESH_RST, 9'd0, 9'd256, 9'd255, 9'd0, 9'd0, 9'd0};
    for (int p = 4; p < 7; p++) limits[p] = THRESH_W'($urandom_range(0, 256));
    for (int p = 0; p < 7; p++) begin
      write_thresh(limits[p]);
      src_eager  = (p == 3);
      sink_eager = (p == 4);
      start = boxes_sent;
      while (boxes_sent - start < ITEMS_PHASE) random_frame();
    end
    src_eager  = 1'b0;
    sink_eager = 1'b0;
    drain();
  endtask

  // main sequence
  initial begin
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_box_left    <= '0;
    in_box_top     <= '0;
    in_box_width   <= '0;
    in_box_height  <= '0;
    in_frame_start <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_iou_thresh <= THRESH_RST;
    kept_total    = 0;
    overlap_limit = THRESH_RST;
    mismatches    = 0;
    boxes_sent    = 0;
    sink_hold     = 0;
    src_eager     = 1'b0;
    sink_eager    = 1'b0;
    for (int i = 0; i < DEPTH; i++) kept_store[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_thresholds();
    test_store_full();
    test_random();
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
